// File: rtl/b128ve_pkg.sv
// ----------------------------------------------------------------------------
// b128ve_pkg
// Shared constants and controller/datapath interface types for the
// base-128 varint encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b128ve_pkg;

   localparam int VALUE_BITS_DEF = 64;   // default encoded value width
   localparam int IN_WIDTH       = 64;   // width of the input value port
   localparam int BYTE_WIDTH     = 8;
   localparam int DIGIT_SHIFT    = 7;

   localparam logic [BYTE_WIDTH-1:0] DIGIT_MASK = 8'h7F;
   localparam logic [BYTE_WIDTH-1:0] CONT_FLAG  = 8'h80;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture a new value, clear digit count
      logic step;   // store one digit, advance working value
      logic emit;   // move top digit into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_digit;  // digit being stored this cycle is the final one
      logic one_left;    // one digit remains to be emitted
      logic out_free;    // output register can take a beat this cycle
   } status_type;

endpackage

`default_nettype wire

// File: rtl/b128ve_ctrl.sv
// ----------------------------------------------------------------------------
// b128ve_ctrl
// Controller state machine: accept, extract digits, emit bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module b128ve_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire b128ve_pkg::status_type status,
   output b128ve_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_EXTRACT = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            cmd.step = 1'b1;
            if (status.last_digit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // take a new beat only between values
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/b128ve_dpath.sv
// ----------------------------------------------------------------------------
// b128ve_dpath
// Datapath: working value, digit store, digit counter, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b128ve_dpath #(
   parameter int VALUE_BITS = b128ve_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [b128ve_pkg::IN_WIDTH-1:0]       req_value,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_valid,
   output logic [b128ve_pkg::BYTE_WIDTH-1:0]          rsp_out_byte,
   output logic                                       rsp_last_byte,
   input  wire b128ve_pkg::cmd_type                   cmd,
   output b128ve_pkg::status_type                     status
);

   localparam int Depth = (VALUE_BITS + b128ve_pkg::DIGIT_SHIFT - 1) / b128ve_pkg::DIGIT_SHIFT;
   localparam int IdxW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);
   localparam logic [CntW-1:0] CntOne  = CntW'(1);
   localparam logic [CntW-1:0] CntLast = CntW'(Depth - 1);

   logic [VALUE_BITS-1:0]             work_ff;
   logic [VALUE_BITS-1:0]             work_shift;
   logic [CntW-1:0]                   cnt_ff;
   logic [CntW-1:0]                   cnt_dec;
   logic [b128ve_pkg::BYTE_WIDTH-1:0] store_ff [Depth];
   logic [b128ve_pkg::BYTE_WIDTH-1:0] digit;
   logic                              rsp_valid_ff;
   logic [b128ve_pkg::BYTE_WIDTH-1:0] rsp_byte_ff;
   logic                              rsp_last_ff;

   assign work_shift = work_ff >> b128ve_pkg::DIGIT_SHIFT;
   assign cnt_dec    = cnt_ff - CntOne;

   // low seven bits; continuation flag on every digit but the first found
   always_comb begin
      digit = {1'b0, work_ff[b128ve_pkg::DIGIT_SHIFT-1:0]} & b128ve_pkg::DIGIT_MASK;
      if (cnt_ff != '0) begin
         digit = digit | b128ve_pkg::CONT_FLAG;
      end
   end

   assign status.last_digit = (work_shift == '0) || (cnt_ff == CntLast);
   assign status.one_left   = (cnt_ff == CntOne);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.load) begin
         work_ff <= req_value[VALUE_BITS-1:0];
         cnt_ff  <= '0;
      end else if (cmd.step) begin
         work_ff <= work_shift - VALUE_BITS'(1);
         cnt_ff  <= cnt_ff + CntOne;
      end else if (cmd.emit) begin
         cnt_ff  <= cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         store_ff[cnt_ff[IdxW-1:0]] <= digit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= store_ff[cnt_dec[IdxW-1:0]];
         rsp_last_ff <= (cnt_ff == CntOne);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/base128_varint_encoder_top.sv
// ----------------------------------------------------------------------------
// base128_varint_encoder_top
// MSB-first base-128 "minus one" varint encoder, one value in, 1..N bytes out.
// ----------------------------------------------------------------------------
// Usage: req_* carries one unsigned value per beat (low VALUE_BITS bits used);
//   rsp_* returns its encoding, most significant byte first, one byte per
//   beat, rsp_last_byte on the final byte; all other bytes have bit 7 set.
//   A beat moves on a rising edge with valid high and stall low.
// Sequence (n = byte count of the value, 1..ceil(VALUE_BITS/7), 10 for 64 bits):
//   accept, then extraction of the n digits (one 7-bit digit per cycle
//   through the shared shift/decrement unit), then output of the n bytes
//   through the single output register. The next value is accepted while the
//   final byte of the previous one still waits in the output register.
// Reset: synchronous, active high; clears the controller, the working value,
//   the digit count and the output valid. The digit store is written before read.
// Receiver stall: holds the output register; emission pauses and the
//   input side stays stalled until the last byte has entered the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module base128_varint_encoder_top #(
   parameter int VALUE_BITS = b128ve_pkg::VALUE_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [b128ve_pkg::IN_WIDTH-1:0]  req_value,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [b128ve_pkg::BYTE_WIDTH-1:0]     rsp_out_byte,
   output logic                                  rsp_last_byte
);

   b128ve_pkg::cmd_type    cmd;
   b128ve_pkg::status_type status;

   // sequence accept / extract / emit
   b128ve_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the working value, digits and the output register
   b128ve_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .cmd           (cmd),
      .status        (status)
   );

   // continuation flag agrees with the last-byte marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_byte == !rsp_out_byte[7]))
      else $error("continuation flag disagrees with last_byte");

   // a taken non-final byte is followed at once by the next one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_byte) |=> rsp_valid)
      else $error("gap inside a value's byte stream");

   // after taking a value the block is stalled in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted back to back");

   // no byte can appear the cycle after a value is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("byte emitted before extraction");

endmodule

`default_nettype wire

// File: tb/sv/tb_base128_varint_encoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base128_varint_encoder_top
// Self-checking bench for the MSB-first base-128 "minus one" varint encoder.
// A queue-fed driver offers 64-bit values and predicts each value's byte
// sequence when the beat is accepted. A monitor compares every result beat,
// byte and last flag, against the oldest predicted beat. Both sides idle at
// random, the receiver holds off once for a long stretch, and a watchdog
// ends a hung run.
// ----------------------------------------------------------------------------
module tb_base128_varint_encoder_top;

   localparam int VALUE_BITS  = b128ve_pkg::VALUE_BITS_DEF;
   localparam int MAX_DIGITS  = 10;               // depth of the digit store
   localparam logic [63:0] VALUE_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS);
   localparam int LONG_HOLD   = 150;              // receiver hold-off, cycles
   localparam int STUCK_LIMIT = 2000;             // cycles without any beat
   localparam int QUIET_WAIT  = 40;               // drain time after last beat
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [b128ve_pkg::BYTE_WIDTH-1:0] code;
      logic                              last;
   } coded_beat_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [b128ve_pkg::IN_WIDTH-1:0]   req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [b128ve_pkg::BYTE_WIDTH-1:0] rsp_out_byte;
   logic                              rsp_last_byte;

   logic [63:0]     pending_values[$];  // values not yet offered
   coded_beat_type  expected_beats[$];  // predicted bytes, oldest first

   // idle modes, switched by the sequencer between phases
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   // long hold-off handshake: the sequencer bumps the request count
   int hold_requests = 0;
   int hold_served   = 0;

   int tx_wait, rx_wait, stuck_cycles;
   int error_count   = 0;
   int values_sent   = 0;
   int bytes_checked = 0;
   bit [MAX_DIGITS:1] lengths_seen = '0;

   base128_varint_encoder_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict the encoding of one value: peel 7-bit digits off the low end,
   // stepping the rest down by one each time, then queue the digits most
   // significant first. Return the number of bytes.
   function automatic int encode_varint(input logic [63:0] value);
      logic [63:0]                       rest;
      logic [b128ve_pkg::BYTE_WIDTH-1:0] digits [MAX_DIGITS];
      int                                count;
      rest  = value & VALUE_MASK;
      count = 0;
      forever begin
         digits[count] = (rest[7:0] & b128ve_pkg::DIGIT_MASK)
                       | ((count != 0) ? b128ve_pkg::CONT_FLAG : 8'h00);
         count++;
         if (rest <= 64'(b128ve_pkg::DIGIT_MASK) || count >= MAX_DIGITS)
            break;
         rest = (rest >> b128ve_pkg::DIGIT_SHIFT) - 64'd1;
      end
      for (int k = count; k > 0; k--)
         expected_beats.push_back('{code: digits[k-1], last: (k == 1)});
      return count;
   endfunction

   // Smallest value whose encoding takes the given number of bytes.
   function automatic logic [63:0] length_floor(input int bytes);
      logic [63:0] floor_value;
      floor_value = '0;
      for (int k = 1; k < bytes; k++)
         floor_value = (floor_value + 64'd1) << b128ve_pkg::DIGIT_SHIFT;
      return floor_value;
   endfunction

   // Random value: mostly a random width so every length shows up, sometimes
   // a value right at a length boundary.
   function automatic logic [63:0] random_value();
      logic [63:0] raw;
      int          width;
      if ($urandom_range(0, 3) == 0)
         return length_floor($urandom_range(2, MAX_DIGITS)) + 64'($urandom_range(0, 2)) - 64'd1;
      width = $urandom_range(1, 64);
      raw   = {$urandom, $urandom};
      return raw >> (64 - width);
   endfunction

   // Driver: predict on every accepted beat, then either hold the stalled
   // beat, idle for the drawn gap, or offer the next pending value.
   always @(posedge clock) begin : driver
      int bytes;
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            bytes = encode_varint(req_value);
            lengths_seen[bytes] = 1'b1;
            values_sent++;
            tx_wait = tx_idle_on ? $urandom_range(0, 6) : 0;
         end
         if (!(req_valid && req_stall)) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (pending_values.size() != 0) begin
               req_valid <= 1'b1;
               req_value <= pending_values.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: a long hold-off when the sequencer asks for one,
   // otherwise a drawn wait after each accepted byte.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            rx_wait = LONG_HOLD;
         end else if (rsp_valid && !rsp_stall) begin
            rx_wait = rx_idle_on ? $urandom_range(0, 6) : 0;
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_stall <= (rx_wait > 0);
      end
   end

   // Monitor: every accepted byte must match the oldest prediction.
   always @(posedge clock) begin : monitor
      coded_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_checked++;
         if (expected_beats.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected byte %h last %b", $time, rsp_out_byte, rsp_last_byte);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_out_byte !== want.code || rsp_last_byte !== want.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                           $time, want.code, want.last, rsp_out_byte, rsp_last_byte);
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d bytes still expected",
                     $time, STUCK_LIMIT, expected_beats.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Sequencer: fill the value queue phase by phase. Work on the falling
   // edge so queue and mode changes never race the clocked blocks.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: each length's smallest value (zero for one byte) and the value
      // just below it, one, the full 64-bit value and alternating bit patterns.
      for (int n = 1; n <= MAX_DIGITS; n++) begin
         pending_values.push_back(length_floor(n));
         if (n > 1)
            pending_values.push_back(length_floor(n) - 64'd1);
      end
      pending_values.push_back(64'd1);
      pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      pending_values.push_back(64'h5555_5555_5555_5555);

      // Pause the sender until every predicted byte has come back.
      while (pending_values.size() != 0 || req_valid || expected_beats.size() != 0)
         @(negedge clock);

      // Back-to-back values against a long receiver hold-off: the encoder
      // fills up and has to stall its input.
      tx_idle_on = 1'b0;
      hold_requests++;
      repeat (25) pending_values.push_back(random_value());
      while (pending_values.size() != 0 || req_valid || expected_beats.size() != 0)
         @(negedge clock);

      // Random values in chunks, each chunk with its own idle mix.
      for (int chunk = 0; chunk < 4; chunk++) begin
         tx_idle_on = (chunk != 1) && (chunk != 3);
         rx_idle_on = (chunk != 2) && (chunk != 3);
         repeat (35) pending_values.push_back(random_value());
         while (pending_values.size() != 0)
            @(negedge clock);
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      // Drain, then give stray bytes a chance to show up.
      while (req_valid || expected_beats.size() != 0)
         @(negedge clock);
      repeat (QUIET_WAIT) @(negedge clock);
      if (expected_beats.size() != 0)
         error_count++;

      $display("Encoded %0d values into %0d checked bytes, %0d failures.",
               values_sent, bytes_checked, error_count);
      $display("Encoding lengths seen (10 down to 1): %b", lengths_seen);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: base128_varint_encoder_top.f
rtl/b128ve_pkg.sv
rtl/b128ve_ctrl.sv
rtl/b128ve_dpath.sv
rtl/base128_varint_encoder_top.sv
tb/sv/tb_base128_varint_encoder_top.sv
